FILE: rtl/ffwt_pkg.sv
package ffwt_pkg;

  localparam int NUM_BINS  = 64;
  localparam int CAP_W     = 32;
  localparam int LEAVES    = 1 << $clog2(NUM_BINS);
  localparam int IDX_W     = $clog2(LEAVES);
  localparam int NODE_W    = IDX_W + 1;
  localparam int BIU_W     = 7;
  localparam int SIZE_W    = 32;
  localparam int BIN_OUT_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int CMP_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);
  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_CAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BIU = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    NODE_HOLD, NODE_ROOT, NODE_LAST, NODE_DEC, NODE_DESC, NODE_UP
  } node_op_t;

  typedef enum logic [1:0] {WR_ROOT, WR_LEFT, WR_RIGHT} win_rsel_t;

  typedef enum logic [2:0] {BR_WIN, BR_LEFT, BR_WA, BR_WB, BR_LEAF} bin_rsel_t;

  typedef enum logic [1:0] {A_HOLD, A_WIN, A_LEFT} a_op_t;

  typedef struct packed {
    node_op_t  node_op;
    win_rsel_t win_rsel;
    bin_rsel_t bin_rsel;
    a_op_t     a_op;
    logic      b_load;
    logic      sa_load;
    logic      win_we;
    logic      fill_we;
    logic      fill_clr;
    logic      place_we;
    logic      load_size;
    logic      emit_reject;
    logic      cap_we;
    logic      biu_we;
  } cmd_t;

  typedef struct packed {
    logic fit;
    logic node_leaf;
    logic node_root;
    logic fill_last;
  } status_t;

  function automatic logic active(logic [IDX_W-1:0] b, logic [BIU_W-1:0] biu);
    return (CMP_W'(b) < CMP_W'(NUM_BINS)) && (CMP_W'(b) < CMP_W'(biu));
  endfunction

endpackage

FILE: rtl/ffwt_ram.sv
module ffwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ffwt_dp.sv
module ffwt_dp
  import ffwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [SIZE_W-1:0]    item_size,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic                 placed,
  output logic [BIN_OUT_W-1:0] bin_index,
  output logic [SIZE_W-1:0]    space_left
);

  logic [NODE_W-1:0] node;
  logic [IDX_W-1:0]  wa;
  logic [IDX_W-1:0]  wb;
  logic [CAP_W-1:0]  sa;
  logic [SIZE_W-1:0] size;
  logic [CAP_W-1:0]  cap;
  logic [BIU_W-1:0]  biu;
  logic [IDX_W-1:0]  fill_cnt;

  logic              win_we;
  logic [IDX_W-1:0]  win_waddr;
  logic [IDX_W-1:0]  win_wdata;
  logic [IDX_W-1:0]  win_raddr;
  logic [IDX_W-1:0]  win_rdata;
  logic              bin_we;
  logic [IDX_W-1:0]  bin_waddr;
  logic [CAP_W-1:0]  bin_wdata;
  logic [IDX_W-1:0]  bin_raddr;
  logic [CAP_W-1:0]  bin_rdata;

  logic [IDX_W-1:0]  left_idx;
  logic [IDX_W-1:0]  right_idx;
  logic              left_leaf;
  logic [IDX_W-1:0]  left_val;
  logic [IDX_W-1:0]  right_val;
  logic [IDX_W-1:0]  leaf_b;
  logic [IDX_W-1:0]  pick;
  logic [CAP_W-1:0]  new_space;

  ffwt_ram #(.WIDTH(IDX_W), .DEPTH(LEAVES)) u_win (
    .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
    .raddr(win_raddr), .rdata(win_rdata)
  );

  ffwt_ram #(.WIDTH(CAP_W), .DEPTH(LEAVES)) u_bin (
    .clk(clk), .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata),
    .raddr(bin_raddr), .rdata(bin_rdata)
  );

  assign left_idx  = IDX_W'({node, 1'b0});
  assign right_idx = IDX_W'({node, 1'b1});
  assign left_leaf = node >= NODE_W'(LEAVES / 2);
  assign left_val  = left_leaf ? left_idx : win_rdata;
  assign right_val = left_leaf ? right_idx : win_rdata;
  assign leaf_b    = node[IDX_W-1:0];
  assign new_space = bin_rdata - CAP_W'(size);

  always_comb begin
    if (!active(wb, biu)) begin
      pick = wa;
    end else if (!active(wa, biu)) begin
      pick = wb;
    end else begin
      pick = (bin_rdata > sa) ? wb : wa;
    end
  end

  always_comb begin
    unique case (cmd.win_rsel)
      WR_ROOT:  win_raddr = IDX_W'(1);
      WR_LEFT:  win_raddr = left_idx;
      WR_RIGHT: win_raddr = right_idx;
      default:  win_raddr = IDX_W'(1);
    endcase
    unique case (cmd.bin_rsel)
      BR_WIN:  bin_raddr = win_rdata;
      BR_LEFT: bin_raddr = left_val;
      BR_WA:   bin_raddr = wa;
      BR_WB:   bin_raddr = wb;
      BR_LEAF: bin_raddr = leaf_b;
      default: bin_raddr = wa;
    endcase
  end

  assign win_we    = cmd.win_we;
  assign win_waddr = node[IDX_W-1:0];
  assign win_wdata = pick;
  assign bin_we    = cmd.fill_we || cmd.place_we;
  assign bin_waddr = cmd.fill_we ? fill_cnt : leaf_b;
  assign bin_wdata = cmd.fill_we ? cap : new_space;

  assign status.fit       = active(wa, biu) && (CMP_W'(bin_rdata) >= CMP_W'(size));
  assign status.node_leaf = node >= NODE_W'(LEAVES);
  assign status.node_root = node == NODE_W'(1);
  assign status.fill_last = fill_cnt == IDX_W'(LEAVES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap      <= CAP_RESET;
      biu      <= BIU_RESET;
      fill_cnt <= '0;
      done     <= 1'b0;
    end else begin
      if (cmd.cap_we) begin
        cap <= CAP_W'(cfg_data);
      end
      if (cmd.biu_we) begin
        biu <= cfg_data[BIU_W-1:0];
      end
      if (cmd.fill_clr) begin
        fill_cnt <= '0;
      end else if (cmd.fill_we) begin
        fill_cnt <= fill_cnt + IDX_W'(1);
      end
      done <= cmd.emit_reject || cmd.place_we;
    end
    unique case (cmd.node_op)
      NODE_HOLD: node <= node;
      NODE_ROOT: node <= NODE_W'(1);
      NODE_LAST: node <= NODE_W'(LEAVES - 1);
      NODE_DEC:  node <= node - NODE_W'(1);
      NODE_DESC: node <= {node[NODE_W-2:0], !status.fit};
      NODE_UP:   node <= node >> 1;
      default:   node <= node;
    endcase
    unique case (cmd.a_op)
      A_HOLD:  wa <= wa;
      A_WIN:   wa <= win_rdata;
      A_LEFT:  wa <= left_val;
      default: wa <= wa;
    endcase
    if (cmd.b_load) begin
      wb <= right_val;
    end
    if (cmd.sa_load) begin
      sa <= bin_rdata;
    end
    if (cmd.load_size) begin
      size <= item_size;
    end
    if (cmd.emit_reject) begin
      placed     <= 1'b0;
      bin_index  <= '0;
      space_left <= '0;
    end else if (cmd.place_we) begin
      placed     <= 1'b1;
      bin_index  <= BIN_OUT_W'(leaf_b);
      space_left <= SIZE_W'(new_space);
    end
  end

endmodule

FILE: rtl/ffwt_ctrl.sv
module ffwt_ctrl
  import ffwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  status_t              status,
  output cmd_t                 cmd,
  output logic                 busy,
  output logic                 cfg_ready
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_ROOT, S_ROOT_CHK, S_D_RA, S_D_RB, S_D_CHK,
    S_L_RD, S_L_WR, S_P_RA, S_P_RB, S_P_SA, S_P_SB, S_P_W
  } state_t;

  state_t state, state_next;
  logic   upd, upd_next;

  assign busy      = state != S_IDLE;
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    cmd = '{node_op: NODE_HOLD, win_rsel: WR_ROOT, bin_rsel: BR_WA, a_op: A_HOLD,
            default: 1'b0};
    state_next = state;
    upd_next   = upd;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_size = 1'b1;
          cmd.node_op   = NODE_ROOT;
          cmd.win_rsel  = WR_ROOT;
          state_next    = S_ROOT;
        end else if (cfg_valid && cfg_index == CFG_CAP) begin
          cmd.cap_we   = 1'b1;
          cmd.fill_clr = 1'b1;
          state_next   = S_FILL;
        end else if (cfg_valid && cfg_index == CFG_BIU) begin
          cmd.biu_we   = 1'b1;
          cmd.node_op  = NODE_LAST;
          upd_next     = 1'b0;
          state_next   = S_P_RA;
        end
      end
      S_FILL: begin
        cmd.fill_we = 1'b1;
        if (status.fill_last) begin
          cmd.node_op = NODE_LAST;
          upd_next    = 1'b0;
          state_next  = S_P_RA;
        end
      end
      S_ROOT: begin
        cmd.a_op     = A_WIN;
        cmd.bin_rsel = BR_WIN;
        state_next   = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        if (status.fit) begin
          state_next = S_D_RA;
        end else begin
          cmd.emit_reject = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_D_RA: begin
        cmd.win_rsel = WR_LEFT;
        state_next   = status.node_leaf ? S_L_RD : S_D_RB;
      end
      S_D_RB: begin
        cmd.a_op     = A_LEFT;
        cmd.bin_rsel = BR_LEFT;
        state_next   = S_D_CHK;
      end
      S_D_CHK: begin
        cmd.node_op = NODE_DESC;
        state_next  = S_D_RA;
      end
      S_L_RD: begin
        cmd.bin_rsel = BR_LEAF;
        state_next   = S_L_WR;
      end
      S_L_WR: begin
        cmd.place_we = 1'b1;
        cmd.node_op  = NODE_UP;
        upd_next     = 1'b1;
        state_next   = S_P_RA;
      end
      S_P_RA: begin
        cmd.win_rsel = WR_LEFT;
        state_next   = S_P_RB;
      end
      S_P_RB: begin
        cmd.a_op     = A_LEFT;
        cmd.win_rsel = WR_RIGHT;
        state_next   = S_P_SA;
      end
      S_P_SA: begin
        cmd.b_load   = 1'b1;
        cmd.bin_rsel = BR_WA;
        state_next   = S_P_SB;
      end
      S_P_SB: begin
        cmd.sa_load  = 1'b1;
        cmd.bin_rsel = BR_WB;
        state_next   = S_P_W;
      end
      S_P_W: begin
        cmd.win_we = 1'b1;
        if (status.node_root) begin
          state_next = S_IDLE;
        end else begin
          cmd.node_op = upd ? NODE_UP : NODE_DEC;
          state_next  = S_P_RA;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      upd   <= 1'b0;
    end else begin
      state <= state_next;
      upd   <= upd_next;
    end
  end

endmodule

FILE: rtl/first_fit_winner_tree_packer.sv
// First-fit bin packer over a max winner tree of 64 bins.
// Input: pulse start with item_size while busy is low; the size is taken at
// that edge. One result per item follows: done is high for exactly one cycle
// with placed, bin_index and space_left. The result cannot be held off; capture
// it on the done cycle.
// Placed item: done follows one read of the winner memory and one of the space
// memory at the root, then a tree descent that per level reads the winner
// memory, then the space memory, then steps down. Busy then stays high for the
// winner update, level by level up to the root, and the next item waits for
// it. Rejected item: done follows the fit check at the root.
// Config: write cfg_index/cfg_data with cfg_valid/cfg_ready while idle. Index 0
// loads bin_capacity and refills all bins, then rebuilds the tree one inner
// node at a time. Index 1 loads bins_in_use and rebuilds only. Other indices
// are dropped.
// Reset: capacity 100, 64 bins in use; the block then runs the refill and
// rebuild pass with busy high before it takes any item.
module first_fit_winner_tree_packer
  import ffwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [SIZE_W-1:0]    item_size,
  output logic                 done,
  output logic                 placed,
  output logic [BIN_OUT_W-1:0] bin_index,
  output logic [SIZE_W-1:0]    space_left,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  ffwt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_valid(cfg_valid),
    .cfg_index(cfg_index), .status(status), .cmd(cmd), .busy(busy),
    .cfg_ready(cfg_ready)
  );

  ffwt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .item_size(item_size),
    .cfg_data(cfg_data), .done(done), .placed(placed), .bin_index(bin_index),
    .space_left(space_left)
  );

endmodule

FILE: tb/sv/tb_first_fit_winner_tree_packer.sv
module tb_first_fit_winner_tree_packer
  import ffwt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);

  typedef struct packed {
    logic                 placed;
    logic [BIN_OUT_W-1:0] bin;
    logic [SIZE_W-1:0]    left;
  } placement_t;

  class packing_board;
    logic [CAP_W-1:0] capacity;
    logic [BIU_W-1:0] bins_live;
    logic [CAP_W-1:0] space [NUM_BINS];
    placement_t       placements [$];
    int               errors;
    int               n_items;
    int               n_placed;
    int               n_writes;

    function new();
      errors = 0;
      n_items = 0;
      n_placed = 0;
      n_writes = 0;
      bins_live = BIU_RESET;
      fill(CAP_RESET);
    endfunction

    function void fill(logic [CAP_W-1:0] cap);
      capacity = cap;
      foreach (space[b]) space[b] = cap;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      n_writes++;
      if (idx == CFG_CAP) fill(val);
      else if (idx == CFG_BIU) bins_live = val[BIU_W-1:0];
    endfunction

    function void note_item(logic [SIZE_W-1:0] size);
      placement_t p;
      p = '0;
      n_items++;
      for (int b = 0; b < NUM_BINS; b++) begin
        if (b < bins_live && space[b] >= size) begin
          space[b] = space[b] - size;
          p.placed = 1'b1;
          p.bin = b[BIN_OUT_W-1:0];
          p.left = space[b];
          n_placed++;
          break;
        end
      end
      placements.push_back(p);
    endfunction

    function void check_result(logic pl, logic [BIN_OUT_W-1:0] bn, logic [SIZE_W-1:0] sl);
      placement_t p;
      if (placements.size() == 0) begin
        $error("result with no item pending: placed %0d bin %0d space %0d", pl, bn, sl);
        errors++;
        return;
      end
      p = placements.pop_front();
      if (pl !== p.placed) begin
        $error("placed: expected %0d actual %0d", p.placed, pl);
        errors++;
      end
      if (bn !== p.bin) begin
        $error("bin_index: expected %0d actual %0d", p.bin, bn);
        errors++;
      end
      if (sl !== p.left) begin
        $error("space_left: expected %0d actual %0d", p.left, sl);
        errors++;
      end
    endfunction

    function int pending();
      return placements.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [SIZE_W-1:0]    item_size;
  logic                 done;
  logic                 placed;
  logic [BIN_OUT_W-1:0] bin_index;
  logic [SIZE_W-1:0]    space_left;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  packing_board board;
  int           idle_cycles;

  first_fit_winner_tree_packer i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_size(item_size),
    .done(done), .placed(placed), .bin_index(bin_index), .space_left(space_left),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) board.check_result(placed, bin_index, space_left);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_item(logic [SIZE_W-1:0] size, int gap_pct);
    start <= 1'b1;
    item_size <= size;
    do @(posedge clk); while (busy);
    board.note_item(size);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold off until every word is back and the tree update has finished
  task automatic drain();
    start <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, val);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    logic [CAP_W-1:0] cap;
    cap = board.capacity;
    case ($urandom_range(9))
      0: return $urandom();
      1: return cap;
      2: return cap + 1;
      3: return 0;
      default: return $urandom_range(0, (cap > 8) ? cap / 4 : cap);
    endcase
  endfunction

  task automatic random_setting();
    case ($urandom_range(5))
      0: write_reg(CFG_CAP, 1);
      1: write_reg(CFG_CAP, 32'hFFFF_FFFF);
      2: write_reg(CFG_CAP, $urandom());
      default: write_reg(CFG_CAP, $urandom_range(1, 1000));
    endcase
    case ($urandom_range(5))
      0: write_reg(CFG_BIU, 1);
      1: write_reg(CFG_BIU, 64);
      2: write_reg(CFG_BIU, $urandom_range(65, 127));
      default: write_reg(CFG_BIU, $urandom_range(1, 64));
    endcase
  endtask

  initial begin
    int gap_pct;
    board = new();
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    item_size = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CAP;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(0, 0);
    send_item(100, 0);
    send_item(101, 0);
    send_item(32'hFFFF_FFFF, 0);
    send_item(1, 0);
    send_item(99, 0);
    send_item(50, 0);
    send_item(50, 0);
    write_reg(CFG_BIU, 0);
    send_item(0, 0);
    write_reg(CFG_BIU, 127);
    send_item(100, 0);
    write_reg(CFG_SPARE, 32'h1234_5678);
    write_reg(CFG_CAP, 0);
    send_item(0, 0);
    send_item(1, 0);
    write_reg(CFG_CAP, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 0);
    send_item(2, 0);
    send_item(1, 0);
    send_item(32'hFFFF_FFFF, 0);
    write_reg(CFG_BIU, 1);
    send_item(32'hFFFF_FFFF, 0);
    send_item(0, 0);

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 19 : (ph == 1) ? 75 : 0;
      for (int k = 0; k < 8; k++) begin
        random_setting();
        for (int n = 0; n < 72; n++) send_item(pick_size(), gap_pct);
        if (k == 3) drain();
      end
    end

    drain();
    $display("covered %0d items (%0d placed, %0d rejected) over %0d register writes",
             board.n_items, board.n_placed, board.n_items - board.n_placed, board.n_writes);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ffwt_pkg.sv
rtl/ffwt_ram.sv
rtl/ffwt_dp.sv
rtl/ffwt_ctrl.sv
rtl/first_fit_winner_tree_packer.sv
tb/sv/tb_first_fit_winner_tree_packer.sv
